/* rtl/core/byte_sliced_conjunctive_scan_core_assert.svh */
// ----------------------------------------------------------------------------
// byte sliced conjunctive scan assertion macros
// clocked property wrappers shared by the scan core rtl
// ----------------------------------------------------------------------------
`ifndef BYTE_SLICED_CONJUNCTIVE_SCAN_CORE_ASSERT_SVH
`define BYTE_SLICED_CONJUNCTIVE_SCAN_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BSCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bscs_pkg.sv */
// ----------------------------------------------------------------------------
// bscs_pkg
// shared types and constants of the byte sliced conjunctive scan core
// ----------------------------------------------------------------------------
`default_nettype none

package bscs_pkg;

  localparam int LIT_W       = 32;
  localparam int SLICE_W     = 64;
  localparam int OUT_W       = 8;
  localparam int REG_COLUMNS = 4;
  localparam int OP_W        = 3;
  localparam int BW_W        = 6;
  localparam int CNT_W       = 2;
  localparam int COL_W       = 2;
  localparam int BIDX_W      = 2;
  localparam int CMP_W       = 12;
  localparam int WIDTHS_W    = 24;
  localparam int COUNTS_W    = 8;
  localparam int NCOLS_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_EQ = 3'd0,
    OP_NE = 3'd1,
    OP_LT = 3'd2,
    OP_LE = 3'd3,
    OP_GT = 3'd4,
    OP_GE = 3'd5
  } bscs_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIT0   = 3'd0,
    REG_LIT1   = 3'd1,
    REG_LIT2   = 3'd2,
    REG_LIT3   = 3'd3,
    REG_CMP    = 3'd4,
    REG_WIDTHS = 3'd5,
    REG_COUNTS = 3'd6,
    REG_NCOLS  = 3'd7
  } bscs_reg_e;

  // per-column mask control from the decode
  typedef struct packed {
    logic upd;
    logic clr;
  } bscs_col_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/bscs_lane.sv */
// ----------------------------------------------------------------------------
// bscs_lane
// unsigned byte compare of one tuple lane against the literal byte
// ----------------------------------------------------------------------------
`default_nettype none

module bscs_lane (
  input  logic [7:0] data_i,
  input  logic [7:0] lit_i,
  output logic       lt_o,
  output logic       gt_o
);

  assign lt_o = data_i < lit_i;
  assign gt_o = data_i > lit_i;

endmodule

`default_nettype wire

/* rtl/core/bscs_column.sv */
// ----------------------------------------------------------------------------
// bscs_column
// less, greater and equal lane masks of one predicate column and its result
// ----------------------------------------------------------------------------
`default_nettype none

module bscs_column #(
  parameter int LANES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bscs_pkg::bscs_col_ctrl_t    ctrl_i,
  input  logic [bscs_pkg::OP_W-1:0]   op_i,
  input  logic [LANES-1:0]            lt_i,
  input  logic [LANES-1:0]            gt_i,
  input  logic [LANES-1:0]            eq_i,
  output logic [LANES-1:0]            eq_next_o,
  output logic [LANES-1:0]            res_next_o
);

  import bscs_pkg::*;

  logic [LANES-1:0] less_q, less_d;
  logic [LANES-1:0] greater_q, greater_d;
  logic [LANES-1:0] equal_q, equal_d;
  bscs_op_e         op;

  assign op = bscs_op_e'(op_i);

  always_comb begin
    less_d    = less_q;
    greater_d = greater_q;
    equal_d   = equal_q;
    if (ctrl_i.upd) begin
      // only lanes still tied can be decided by this byte
      unique case (op) inside
        OP_LT, OP_LE: less_d    = less_q | (equal_q & lt_i);
        OP_GT, OP_GE: greater_d = greater_q | (equal_q & gt_i);
        default: ;
      endcase
      equal_d = equal_q & eq_i;
    end
  end

  always_comb begin
    unique case (op)
      OP_EQ:   res_next_o = equal_d;
      OP_NE:   res_next_o = ~equal_d;
      OP_LT:   res_next_o = less_d;
      OP_LE:   res_next_o = less_d | equal_d;
      OP_GT:   res_next_o = greater_d;
      OP_GE:   res_next_o = greater_d | equal_d;
      default: res_next_o = '0;
    endcase
  end

  assign eq_next_o = equal_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      less_q    <= '0;
      greater_q <= '0;
      equal_q   <= {LANES{1'b1}};
    end else if (ctrl_i.clr) begin
      less_q    <= '0;
      greater_q <= '0;
      equal_q   <= {LANES{1'b1}};
    end else begin
      less_q    <= less_d;
      greater_q <= greater_d;
      equal_q   <= equal_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/byte_sliced_conjunctive_scan_core.sv */
// ----------------------------------------------------------------------------
// byte_sliced_conjunctive_scan_core
// conjunction of up to four column predicates over tuples held as byte slices
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------
//   in       | sink      | in_valid_i/in_ready_o  | column, byte_index, slice,
//            |           |                        | skip_slice, last
//   out      | source    | out_valid_o/out_ready_i| match_mask, all_decided,
//            |           |                        | segment_done
//   cfg      | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// one item per cycle unless the output stalls, one registered result per item;
// the only loop is the addressed column's mask read-modify-write, held in flops
// reset clears all masks at once, no sweep; cfg is always ready
// the output register takes a new item whenever it is empty or being drained
// ----------------------------------------------------------------------------
`default_nettype none

module byte_sliced_conjunctive_scan_core #(
  parameter int NUM_COLUMNS = 4,
  parameter int LANES       = 8,
  parameter int MAX_BYTES   = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bscs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bscs_pkg::CFG_DATA_W-1:0]   cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bscs_pkg::COL_W-1:0]        column_i,
  input  logic [bscs_pkg::BIDX_W-1:0]       byte_index_i,
  input  logic [bscs_pkg::SLICE_W-1:0]      slice_i,
  input  logic                              skip_slice_i,
  input  logic                              last_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bscs_pkg::OUT_W-1:0]        match_mask_o,
  output logic                              all_decided_o,
  output logic                              segment_done_o
);

  import bscs_pkg::*;

  localparam int NCOL = (NUM_COLUMNS < REG_COLUMNS) ? NUM_COLUMNS : REG_COLUMNS;

  // configuration registers
  logic [LIT_W-1:0]    lit_q [REG_COLUMNS];
  logic [CMP_W-1:0]    cmp_codes_q;
  logic [WIDTHS_W-1:0] bit_widths_q;
  logic [COUNTS_W-1:0] byte_counts_q;
  logic [NCOLS_W-1:0]  ncols_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COLUMNS; i++) lit_q[i] <= '0;
      cmp_codes_q   <= '0;
      bit_widths_q  <= '0;
      byte_counts_q <= '0;
      ncols_q       <= NCOLS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (bscs_reg_e'(cfg_index_i))
        REG_LIT0, REG_LIT1, REG_LIT2, REG_LIT3:
          lit_q[cfg_index_i[COL_W-1:0]] <= cfg_data_i;
        REG_CMP:    cmp_codes_q   <= cfg_data_i[CMP_W-1:0];
        REG_WIDTHS: bit_widths_q  <= cfg_data_i[WIDTHS_W-1:0];
        REG_COUNTS: byte_counts_q <= cfg_data_i[COUNTS_W-1:0];
        REG_NCOLS:  ncols_q       <= cfg_data_i[NCOLS_W-1:0];
        default: ;
      endcase
    end
  end

  // columns taking part in the conjunction
  logic [NCOLS_W-1:0] n_used;
  always_comb begin
    if (ncols_q == '0) n_used = NCOLS_W'(1);
    else if (ncols_q > NCOLS_W'(NCOL)) n_used = NCOLS_W'(NCOL);
    else n_used = ncols_q;
  end

  // literal byte of the addressed column, left aligned to its slice count
  logic [2:0]       cnt_p1;
  logic [2:0]       nb;
  logic [BW_W-1:0]  cap;
  logic [BW_W-1:0]  bw_raw;
  logic [BW_W-1:0]  bw;
  logic [BW_W-1:0]  shamt;
  logic [LIT_W-1:0] lit_mask;
  logic [LIT_W-1:0] lit_aligned;
  logic [1:0]       byte_pos;
  logic             byte_ok;
  logic [7:0]       lit_sel;

  always_comb begin
    cnt_p1 = {1'b0, byte_counts_q[CNT_W*column_i +: CNT_W]} + 3'd1;
    nb     = (4'(cnt_p1) > 4'(MAX_BYTES)) ? 3'(MAX_BYTES) : cnt_p1;
    cap    = {nb, 3'b000};
    bw_raw = bit_widths_q[BW_W*column_i +: BW_W];
    if (bw_raw == '0) bw = BW_W'(1);
    else if (bw_raw > cap) bw = cap;
    else bw = bw_raw;
    lit_mask    = LIT_W'((64'd1 << bw) - 64'd1);
    shamt       = cap - bw;
    lit_aligned = (lit_q[column_i] & lit_mask) << shamt;
    byte_ok     = {1'b0, byte_index_i} < nb;
    byte_pos    = 2'(nb - 3'd1 - {1'b0, byte_index_i});
    lit_sel     = lit_aligned[{byte_pos, 3'b000} +: 8];
  end

  // lane compares
  logic [LANES-1:0] lane_lt;
  logic [LANES-1:0] lane_gt;
  logic [LANES-1:0] lane_eq;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    bscs_lane u_lane (
      .data_i (slice_i[8*l +: 8]),
      .lit_i  (lit_sel),
      .lt_o   (lane_lt[l]),
      .gt_o   (lane_gt[l])
    );
  end

  assign lane_eq = ~(lane_lt | lane_gt);

  // per-column mask state
  logic             in_acc;
  logic [LANES-1:0] eq_next  [NCOL];
  logic [LANES-1:0] res_next [NCOL];

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  for (genvar c = 0; c < NCOL; c++) begin : g_col
    bscs_col_ctrl_t ctrl;

    assign ctrl.upd = in_acc && !skip_slice_i && byte_ok &&
                      (column_i == COL_W'(c)) && (NCOLS_W'(c) < n_used);
    assign ctrl.clr = in_acc && last_i;

    bscs_column #(
      .LANES (LANES)
    ) u_column (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .op_i       (cmp_codes_q[OP_W*c +: OP_W]),
      .lt_i       (lane_lt),
      .gt_i       (lane_gt),
      .eq_i       (lane_eq),
      .eq_next_o  (eq_next[c]),
      .res_next_o (res_next[c])
    );
  end

  // merge across columns in use
  logic [LANES-1:0] any_equal;
  logic [LANES-1:0] conj;

  always_comb begin
    any_equal = '0;
    conj      = {LANES{1'b1}};
    for (int c = 0; c < NCOL; c++) begin
      if (NCOLS_W'(c) < n_used) begin
        any_equal = any_equal | eq_next[c];
        conj      = conj & res_next[c];
      end
    end
  end

  // output register
  logic             out_valid_q;
  logic [OUT_W-1:0] match_mask_q;
  logic             all_decided_q;
  logic             segment_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      match_mask_q   <= last_i ? OUT_W'(conj) : '0;
      all_decided_q  <= (any_equal == '0);
      segment_done_q <= last_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_mask_o   = match_mask_q;
  assign all_decided_o  = all_decided_q;
  assign segment_done_o = segment_done_q;

`include "byte_sliced_conjunctive_scan_core_assert.svh"

  `BSCS_ASSERT_NEXT(a_acc_gives_result, clk_i, rst_ni, in_acc, out_valid_o, "item lost")
  `BSCS_ASSERT_IMPL(a_empty_is_ready, clk_i, rst_ni, !out_valid_o, in_ready_o, "empty stall")
  `BSCS_ASSERT_IMPL(a_mask_only_on_done, clk_i, rst_ni, out_valid_o && !segment_done_o, match_mask_o == '0, "mask before done")

endmodule

`default_nettype wire
